@@ src/skvt_pkg.sv @@
// Package for the sorted key and value table.
// Holds default sizes, operation and status codes, and the cell control types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY_DEF    = 512;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int GROUP_SIZE      = 16;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_REJECTED  = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    typedef struct packed {
        logic     cmp_en;
        cell_op_t op;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_CMP,
        FSM_REDUCE,
        FSM_MERGE
    } fsm_t;

endpackage

`default_nettype wire

@@ src/skvt_cell.sv @@
// One cell of the sorted chain: holds a single key and value with its valid bit.
// Compares against the broadcast key and shifts to or from its neighbours.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
#(
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_ctrl_t             ctrl,
    input  wire logic [KEY_WIDTH-1:0]   req_key,
    input  wire logic [VALUE_WIDTH-1:0] req_value,
    input  wire logic                   left_lt,
    input  wire logic [KEY_WIDTH-1:0]   left_key,
    input  wire logic [VALUE_WIDTH-1:0] left_value,
    input  wire logic                   left_valid,
    input  wire logic [KEY_WIDTH-1:0]   right_key,
    input  wire logic [VALUE_WIDTH-1:0] right_value,
    input  wire logic                   right_valid,
    output logic [KEY_WIDTH-1:0]        cell_key,
    output logic [VALUE_WIDTH-1:0]      cell_value,
    output logic                        cell_valid,
    output logic                        cell_lt,
    output logic                        cell_eq
);

    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   lt_reg;
    logic                   lt_next;
    logic                   eq_reg;
    logic                   eq_next;

    // Cells below the insertion point hold; the rest load the request or a neighbour.
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        valid_next = valid_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = valid_reg && (key_reg < req_key);
            eq_next = valid_reg && (key_reg == req_key);
        end
        case (ctrl.op)
            OP_INSERT:
            begin
                if (!lt_reg)
                begin
                    if (left_lt)
                    begin
                        key_next   = req_key;
                        value_next = req_value;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        key_next   = left_key;
                        value_next = left_value;
                        valid_next = left_valid;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (!lt_reg)
                begin
                    key_next   = right_key;
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign cell_key   = key_reg;
    assign cell_value = value_reg;
    assign cell_valid = valid_reg;
    assign cell_lt    = lt_reg;
    assign cell_eq    = eq_reg;

endmodule

`default_nettype wire

@@ src/skvt_group_reduce.sv @@
// Registered reduction over one group of cells.
// Encodes the boundary position and selects the matching value and hit flag.
// Depends on skvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skvt_group_reduce
    import skvt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int POS_W       = 9,
    parameter int BASE        = 0
)
(
    input  wire logic                   clk,
    input  wire logic [GROUP_SIZE-1:0]  bnd,
    input  wire logic [GROUP_SIZE-1:0]  eq,
    input  wire logic [VALUE_WIDTH-1:0] values [GROUP_SIZE],
    output logic [POS_W-1:0]            pos_part,
    output logic [VALUE_WIDTH-1:0]      value_part,
    output logic                        hit_part
);

    logic [POS_W-1:0]       pos_next;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   hit_next;
    logic [POS_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic                   hit_reg;

    always_comb
    begin
        pos_next   = '0;
        value_next = '0;
        hit_next   = |eq;
        for (int j = 0; j < GROUP_SIZE; j++)
        begin
            if (bnd[j])
            begin
                pos_next = pos_next | POS_W'(BASE + j);
            end
            if (eq[j])
            begin
                value_next = value_next | values[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        value_reg <= value_next;
        hit_reg   <= hit_next;
    end

    assign pos_part   = pos_reg;
    assign value_part = value_reg;
    assign hit_part   = hit_reg;

endmodule

`default_nettype wire

@@ src/sorted_key_value_table_top.sv @@
// Top level of the sorted key and value table: a chain of cells with a reduction tree.
// Depends on skvt_pkg, skvt_cell and skvt_group_reduce.
//
// Requests arrive as words on the input channel (in_valid, in_ready) with mode, key,
// value_in and start_hint; one result word per request leaves on the output channel
// (out_valid, out_ready) with status, position, value_out and entry_count.
// Every cell compares its key with the request key in the compare state, the groups
// of cells reduce their flags in the reduce state, and the merge state merges the
// groups, decides the outcome, shifts the chain and loads the result register.
// A new request is taken only in the idle state, after the last has left the merge
// state, so the block is through with one request before it takes the next; the
// compare, reduce and merge sequence over the cell chain sets the pace.
// The start hint has no effect on any result here.
// While a result waits for the receiver the block still takes the next request; that
// request then holds in its merge cycle until the output register is free.
// Reset empties the table at once by clearing every valid bit and the entry count.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table_top
    import skvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int POS_W      = $clog2(CAPACITY),
    localparam int CNT_W      = $clog2(CAPACITY + 1)
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             mode,
    input  wire logic [KEY_WIDTH-1:0]   key,
    input  wire logic [VALUE_WIDTH-1:0] value_in,
    input  wire logic [POS_W-1:0]       start_hint,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  status,
    output logic [POS_W-1:0]            position,
    output logic [VALUE_WIDTH-1:0]      value_out,
    output logic [CNT_W-1:0]            entry_count
);

    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS  = NUM_GROUPS * GROUP_SIZE;

    fsm_t                   state_reg;
    fsm_t                   state_next;
    logic [1:0]             mode_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [POS_W-1:0]       position_reg;
    logic [POS_W-1:0]       position_next;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic [VALUE_WIDTH-1:0] value_out_next;

    logic                   accept;
    logic                   slot_free;
    logic                   commit;
    logic                   cmp_en;
    cell_op_t               decided_op;
    cell_ctrl_t             ctrl;

    logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]    cell_valid;
    logic [CAPACITY-1:0]    cell_lt;
    logic [CAPACITY-1:0]    cell_eq;

    logic [PAD_CELLS-1:0]   bnd_pad;
    logic [PAD_CELLS-1:0]   eq_pad;
    logic [VALUE_WIDTH-1:0] value_pad  [PAD_CELLS];

    logic [POS_W-1:0]       grp_pos    [NUM_GROUPS];
    logic [VALUE_WIDTH-1:0] grp_value  [NUM_GROUPS];
    logic [NUM_GROUPS-1:0]  grp_hit;

    logic [POS_W-1:0]       lb_pos;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic                   hit;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_CMP;
                end
            end
            FSM_CMP:
            begin
                state_next = FSM_REDUCE;
            end
            FSM_REDUCE:
            begin
                state_next = FSM_MERGE;
            end
            FSM_MERGE:
            begin
                if (slot_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmp_en   = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            FSM_IDLE:
            begin
                in_ready = 1'b1;
            end
            FSM_CMP:
            begin
                cmp_en = 1'b1;
            end
            FSM_MERGE:
            begin
                commit = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            key_reg   <= key;
            value_reg <= value_in;
        end
        status_reg    <= status_next;
        position_reg  <= position_next;
        value_out_reg <= value_out_next;
    end

    assign ctrl.cmp_en = cmp_en;
    assign ctrl.op     = commit ? decided_op : OP_NONE;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                   left_lt;
            logic [KEY_WIDTH-1:0]   left_key;
            logic [VALUE_WIDTH-1:0] left_value;
            logic                   left_valid;
            logic [KEY_WIDTH-1:0]   right_key;
            logic [VALUE_WIDTH-1:0] right_value;
            logic                   right_valid;

            if (i == 0)
            begin : g_first
                assign left_lt    = 1'b1;
                assign left_key   = '0;
                assign left_value = '0;
                assign left_valid = 1'b0;
            end
            else
            begin : g_inner_left
                assign left_lt    = cell_lt[i-1];
                assign left_key   = cell_key[i-1];
                assign left_value = cell_value[i-1];
                assign left_valid = cell_valid[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_key   = '0;
                assign right_value = '0;
                assign right_valid = 1'b0;
            end
            else
            begin : g_inner_right
                assign right_key   = cell_key[i+1];
                assign right_value = cell_value[i+1];
                assign right_valid = cell_valid[i+1];
            end

            skvt_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .req_key     (key_reg),
                .req_value   (value_reg),
                .left_lt     (left_lt),
                .left_key    (left_key),
                .left_value  (left_value),
                .left_valid  (left_valid),
                .right_key   (right_key),
                .right_value (right_value),
                .right_valid (right_valid),
                .cell_key    (cell_key[i]),
                .cell_value  (cell_value[i]),
                .cell_valid  (cell_valid[i]),
                .cell_lt     (cell_lt[i]),
                .cell_eq     (cell_eq[i])
            );

            assign bnd_pad[i]   = !cell_lt[i] && left_lt;
            assign eq_pad[i]    = cell_eq[i];
            assign value_pad[i] = cell_value[i];
        end

        for (i = CAPACITY; i < PAD_CELLS; i++)
        begin : g_pad
            assign bnd_pad[i]   = 1'b0;
            assign eq_pad[i]    = 1'b0;
            assign value_pad[i] = '0;
        end

        for (i = 0; i < NUM_GROUPS; i++)
        begin : g_group
            skvt_group_reduce #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .POS_W       (POS_W),
                .BASE        (i * GROUP_SIZE)
            ) u_group (
                .clk        (clk),
                .bnd        (bnd_pad[i*GROUP_SIZE +: GROUP_SIZE]),
                .eq         (eq_pad[i*GROUP_SIZE +: GROUP_SIZE]),
                .values     (value_pad[i*GROUP_SIZE +: GROUP_SIZE]),
                .pos_part   (grp_pos[i]),
                .value_part (grp_value[i]),
                .hit_part   (grp_hit[i])
            );
        end
    endgenerate

    always_comb
    begin
        lb_pos    = '0;
        hit_value = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            lb_pos    = lb_pos | grp_pos[g];
            hit_value = hit_value | grp_value[g];
        end
        hit = |grp_hit;
    end

    always_comb
    begin
        decided_op     = OP_NONE;
        status_next    = status_reg;
        position_next  = position_reg;
        value_out_next = value_out_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (commit)
        begin
            out_valid_next = 1'b1;
            status_next    = STATUS_REJECTED;
            position_next  = '0;
            value_out_next = '0;
            case (mode_reg)
                MODE_INSERT:
                begin
                    if ((key_reg != '0) && (value_reg != '0) &&
                        (count_reg < CNT_W'(CAPACITY)) && !hit)
                    begin
                        decided_op    = OP_INSERT;
                        status_next   = STATUS_OK;
                        position_next = lb_pos;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                MODE_REMOVE:
                begin
                    if ((key_reg != '0) && hit)
                    begin
                        decided_op    = OP_REMOVE;
                        status_next   = STATUS_OK;
                        position_next = lb_pos;
                        count_next    = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                MODE_LOOKUP:
                begin
                    if (key_reg != '0)
                    begin
                        if (hit)
                        begin
                            status_next    = STATUS_OK;
                            position_next  = lb_pos;
                            value_out_next = hit_value;
                        end
                        else
                        begin
                            status_next = STATUS_NOT_FOUND;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign value_out   = value_out_reg;
    assign entry_count = count_reg;

endmodule

`default_nettype wire
